FILE: rtl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

   localparam int unsigned LenWidth   = 64;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned RspDataW   = 80;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   localparam logic [6:0] LEN7_MASK  = 7'h7F;
   localparam logic [3:0] OPCODE_MSK = 4'hF;
   localparam logic [6:0] LEN7_MAX   = 7'd125;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_NOT_MASKED = 2'd1;
   localparam logic [1:0] ERR_SHORT_BUF  = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          data_byte;
      logic                final_flag;
      logic [3:0]          frame_opcode;
      logic [LenWidth-1:0] payload_length;
      logic                last_payload;
      logic [1:0]          error_code;
   } rsp_item_type;

   // Up to two result items per input item
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res_a;
      rsp_item_type res_b;
   } parse_out_type;

   function automatic rsp_item_type make_error(input logic [1:0] code);
      rsp_item_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/wsd_parser.sv
`default_nettype none

module wsd_parser
   import wsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [LenWidth-1:0] csr_value,
   input  wire logic                item_valid,
   input  wire logic [7:0]          item_byte,
   input  wire logic                item_eob,
   output parse_out_type            parse_out
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4,
      PH_SKIP = 3'd5
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [3:0]          opcode_ff, opcode_in;
   logic [3:0]          len_left_ff, len_left_in;
   logic [LenWidth-1:0] len_acc_ff, len_acc_in;
   logic [31:0]         mask_key_ff, mask_key_in;
   logic [1:0]          key_idx_ff, key_idx_in;
   logic [LenWidth-1:0] remain_ff, remain_in;
   logic [LenWidth-1:0] max_len_ff;

   logic [6:0]          len7;
   logic [7:0]          key_byte;
   phase_type           done_phase;

   assign len7       = item_byte[6:0] & LEN7_MASK;
   assign key_byte   = mask_key_ff[{~key_idx_ff, 3'b000} +: 8];
   assign done_phase = item_eob ? PH_HDR0 : PH_SKIP;

   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      len_left_in = len_left_ff;
      len_acc_in  = len_acc_ff;
      mask_key_in = mask_key_ff;
      key_idx_in  = key_idx_ff;
      remain_in   = remain_ff;
      parse_out   = '0;

      if (item_valid) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in      = item_byte[7];
               opcode_in   = item_byte[3:0] & OPCODE_MSK;
               len_left_in = '0;
               len_acc_in  = '0;
               mask_key_in = '0;
               key_idx_in  = '0;
               remain_in   = '0;
               if (item_eob) begin
                  parse_out.res_a = make_error(ERR_SHORT_BUF);
                  parse_out.count = 2'd1;
                  phase_in        = PH_HDR0;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (!item_byte[7]) begin
                  parse_out.res_a = make_error(ERR_NOT_MASKED);
                  parse_out.count = 2'd1;
                  phase_in        = done_phase;
               end else begin
                  key_idx_in = '0;
                  if (len7 == LEN7_EXT16) begin
                     len_acc_in  = '0;
                     len_left_in = 4'd2;
                     phase_in    = PH_EXT;
                  end else if (len7 == LEN7_EXT64) begin
                     len_acc_in  = '0;
                     len_left_in = 4'd8;
                     phase_in    = PH_EXT;
                  end else begin
                     len_acc_in = {{(LenWidth-7){1'b0}}, len7};
                     phase_in   = PH_KEY;
                  end
                  if (item_eob) begin
                     parse_out.res_a = make_error(ERR_SHORT_BUF);
                     parse_out.count = 2'd1;
                     phase_in        = PH_HDR0;
                  end
               end
            end
            PH_EXT: begin
               len_acc_in  = {len_acc_ff[LenWidth-9:0], item_byte};
               len_left_in = len_left_ff - 4'd1;
               if (len_left_in == 4'd0) begin
                  phase_in = PH_KEY;
               end
               if (item_eob) begin
                  parse_out.res_a = make_error(ERR_SHORT_BUF);
                  parse_out.count = 2'd1;
                  phase_in        = PH_HDR0;
               end
            end
            PH_KEY: begin
               mask_key_in = {mask_key_ff[23:0], item_byte};
               if (key_idx_ff == 2'd3) begin
                  key_idx_in = '0;
                  if (len_acc_ff > max_len_ff) begin
                     parse_out.res_a = make_error(ERR_TOO_LONG);
                     parse_out.count = 2'd1;
                     phase_in        = done_phase;
                  end else begin
                     parse_out.res_a.kind           = KIND_HEADER;
                     parse_out.res_a.final_flag     = fin_ff;
                     parse_out.res_a.frame_opcode   = opcode_ff;
                     parse_out.res_a.payload_length = len_acc_ff;
                     parse_out.count                = 2'd1;
                     remain_in                      = len_acc_ff;
                     if (len_acc_ff == '0) begin
                        phase_in = done_phase;
                     end else begin
                        phase_in = PH_DATA;
                        if (item_eob) begin
                           parse_out.res_b = make_error(ERR_SHORT_BUF);
                           parse_out.count = 2'd2;
                           phase_in        = PH_HDR0;
                        end
                     end
                  end
               end else begin
                  key_idx_in = key_idx_ff + 2'd1;
                  if (item_eob) begin
                     parse_out.res_a = make_error(ERR_SHORT_BUF);
                     parse_out.count = 2'd1;
                     phase_in        = PH_HDR0;
                  end
               end
            end
            PH_DATA: begin
               key_idx_in                   = key_idx_ff + 2'd1;
               remain_in                    = remain_ff - {{(LenWidth-1){1'b0}}, 1'b1};
               parse_out.res_a.kind         = KIND_PAYLOAD;
               parse_out.res_a.data_byte    = item_byte ^ key_byte;
               parse_out.res_a.last_payload = (remain_in == '0);
               parse_out.count              = 2'd1;
               if (remain_in == '0) begin
                  phase_in = done_phase;
               end else if (item_eob) begin
                  parse_out.res_b = make_error(ERR_SHORT_BUF);
                  parse_out.count = 2'd2;
                  phase_in        = PH_HDR0;
               end
            end
            default: begin
               // Drop bytes until the buffer ends
               if (item_eob) begin
                  phase_in = PH_HDR0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         fin_ff      <= 1'b0;
         opcode_ff   <= '0;
         len_left_ff <= '0;
         len_acc_ff  <= '0;
         mask_key_ff <= '0;
         key_idx_ff  <= '0;
         remain_ff   <= '0;
         max_len_ff  <= '1;
      end else begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         len_left_ff <= len_left_in;
         len_acc_ff  <= len_acc_in;
         mask_key_ff <= mask_key_in;
         key_idx_ff  <= key_idx_in;
         remain_ff   <= remain_in;
         if (csr_we) begin
            max_len_ff <= csr_value;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/wsd_rsp_queue.sv
`default_nettype none

module wsd_rsp_queue
   import wsd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  parse_out_type      push,
   input  wire logic          pop,
   output rsp_item_type       head,
   output logic               not_empty,
   output logic [QueuePtrW:0] fill
);

   rsp_item_type         slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]   fill_ff, fill_in;
   logic                 do_pop;

   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign fill      = fill_ff;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(do_pop);
      fill_in   = fill_ff + (QueuePtrW+1)'(push.count) - (QueuePtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.res_a;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + QueuePtrW'(1)] <= push.res_b;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
`default_nettype none

// WebSocket client frame deframer. Feed the received buffer one byte per item
// on req_, with req_tlast set on the buffer's last byte. Each frame gives one
// header item (FIN, opcode, payload length) once its masking key is in, then
// one item per payload byte, unmasked with the rotating key, with rsp_tlast on
// the final byte. Errors (frame not masked, buffer ended inside a frame,
// length above the limit in csr_data) come out as error items, after which
// bytes are dropped until the buffer ends. Throughput is one byte per clock
// while the result queue has room: a byte is captured in the input register,
// decoded combinationally against the frame state, and its results (one, or
// two when the buffer ends before a payload is complete) are written into a
// four-entry result queue, which shows them to the sink. The input register
// only advances while the queue has room for two results, so a stalled sink
// holds back req_tready once three results are waiting and a byte sits in the
// input register. csr_ready is always high; write the limit only while no
// frame is in flight.
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // in_byte
   input  wire logic                req_tlast,   // end_of_buffer

   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // data_byte[7:0], final_flag[8], frame_opcode[12:9], payload_length[76:13],
   // error_code[78:77], zero[79]
   output logic [RspDataW-1:0]      rsp_tdata,
   output logic [1:0]               rsp_tuser,   // kind
   output logic                     rsp_tlast,   // last_payload

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [LenWidth-1:0] csr_data     // max_payload_length
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_eob_ff;
   logic          advance;
   logic          req_fire;

   parse_out_type      parse_out;
   rsp_item_type       head;
   logic               not_empty;
   logic [QueuePtrW:0] fill;

   // Advance the input register only when the queue can take two results
   assign advance    = in_valid_ff && (fill <= (QueuePtrW+1)'(QueueDepth - 2));
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload of the input register: hold unless a new item is taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
   end

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .item_valid (advance),
      .item_byte  (in_byte_ff),
      .item_eob   (in_eob_ff),
      .parse_out  (parse_out)
   );

   wsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_out),
      .pop       (rsp_tready),
      .head      (head),
      .not_empty (not_empty),
      .fill      (fill)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_payload;
   assign rsp_tdata  = {1'b0, head.error_code, head.payload_length,
                        head.frame_opcode, head.final_flag, head.data_byte};

endmodule

`default_nettype wire

FILE: rtl/wsd_checker.sv
`default_nettype none

module wsd_checker
   import wsd_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata,
   input wire logic [1:0]          rsp_tuser,
   input wire logic                rsp_tlast
);

   // Queue is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // Kind code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_HEADER || rsp_tuser == KIND_PAYLOAD
                      || rsp_tuser == KIND_ERROR))
      else $error("invalid result kind");

   // Only a payload item can close the frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_PAYLOAD))
      else $error("last flag on a non-payload item");

   // Errors carry a code, other items do not
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_ERROR) == (rsp_tdata[78:77] != ERR_NONE)))
      else $error("error code does not match kind");

   // Stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

FILE: test/websocket_frame_deframer_test.sv
module websocket_frame_deframer_test
   import wsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 200;     // eight phases, at least 1600 bytes in all
   localparam int SINK_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;         // lets the input register and result queue settle
   localparam int CYCLE_LIMIT = 1_000_000;

   // Idle styles for either side
   localparam int IDLE_NONE = 0;
   localparam int IDLE_ALWAYS = 1;
   localparam int IDLE_SPARSE = 2;

   typedef enum logic [2:0] {
      AWAIT_HDR0,
      AWAIT_HDR1,
      READ_EXT_LEN,
      READ_KEY,
      PASS_PAYLOAD,
      DISCARD
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       ends_buffer;
   } raw_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LenWidth-1:0] csr_data = '0;

   // Bytes waiting to be offered, and results the frame decoder still owes
   raw_byte_type unsent_bytes[$];
   rsp_item_type frame_results_due[$];
   logic [7:0]   frame_bytes[$];           // scratch buffer while one is built

   // Mirror of the decoder: frame state plus the length limit
   parse_phase_type parse_phase = AWAIT_HDR0;
   logic          frame_fin = 1'b0;
   logic [3:0]    frame_op = '0;
   logic [3:0]    ext_left = '0;
   logic [63:0]   decoded_length = '0;
   logic [31:0]   key_word = '0;
   logic [1:0]    key_pos = '0;
   logic [63:0]   bytes_remaining = '0;
   logic [63:0]   length_limit = '1;

   int  sender_mode = IDLE_NONE;
   int  receiver_mode = IDLE_NONE;
   int  req_gap = 0;
   int  rsp_gap = 0;
   bit  req_accepted = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  phase_bytes = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;

   websocket_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw the idle cycles that precede the next item on one side
   function automatic int draw_gap(input int mode);
      if (mode == IDLE_ALWAYS) begin
         return $urandom_range(0, 15);
      end
      if (mode == IDLE_SPARSE && $urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 15);
      end
      return 0;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
      end
   endtask

   // Log an error item and either restart at the next byte or drop bytes
   // until the buffer ends
   task automatic abort_frame(input logic [1:0] code, input logic eob);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      frame_results_due.push_back(r);
      parse_phase = eob ? AWAIT_HDR0 : DISCARD;
   endtask

   // Advance the mirrored frame state by one accepted byte and queue the
   // results it causes
   task automatic decode_frame_byte(input logic [7:0] b, input logic eob);
      rsp_item_type r;
      r = '0;
      case (parse_phase)
         AWAIT_HDR0: begin
            frame_fin = b[7];
            frame_op = b[3:0];
            ext_left = '0;
            decoded_length = '0;
            key_word = '0;
            key_pos = '0;
            bytes_remaining = '0;
            if (eob) abort_frame(ERR_SHORT_BUF, eob);
            else parse_phase = AWAIT_HDR1;
         end
         AWAIT_HDR1: begin
            if (!b[7]) begin
               abort_frame(ERR_NOT_MASKED, eob);
            end else begin
               decoded_length = '0;
               key_pos = '0;
               if (b[6:0] == LEN7_EXT16) begin
                  ext_left = 4'd2;
                  parse_phase = READ_EXT_LEN;
               end else if (b[6:0] == LEN7_EXT64) begin
                  ext_left = 4'd8;
                  parse_phase = READ_EXT_LEN;
               end else begin
                  decoded_length = 64'(b[6:0]);
                  parse_phase = READ_KEY;
               end
               if (eob) abort_frame(ERR_SHORT_BUF, eob);
            end
         end
         READ_EXT_LEN: begin
            decoded_length = {decoded_length[55:0], b};
            ext_left = ext_left - 4'd1;
            if (ext_left == 4'd0) parse_phase = READ_KEY;
            if (eob) abort_frame(ERR_SHORT_BUF, eob);
         end
         READ_KEY: begin
            key_word = {key_word[23:0], b};
            if (key_pos == 2'd3) begin
               key_pos = '0;
               if (decoded_length > length_limit) begin
                  abort_frame(ERR_TOO_LONG, eob);
               end else begin
                  r.kind = KIND_HEADER;
                  r.final_flag = frame_fin;
                  r.frame_opcode = frame_op;
                  r.payload_length = decoded_length;
                  frame_results_due.push_back(r);
                  bytes_remaining = decoded_length;
                  if (bytes_remaining == '0) begin
                     parse_phase = eob ? AWAIT_HDR0 : DISCARD;
                  end else begin
                     parse_phase = PASS_PAYLOAD;
                     if (eob) abort_frame(ERR_SHORT_BUF, eob);
                  end
               end
            end else begin
               key_pos = key_pos + 2'd1;
               if (eob) abort_frame(ERR_SHORT_BUF, eob);
            end
         end
         PASS_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.data_byte = b ^ key_word[31 - 8 * int'(key_pos) -: 8];
            key_pos = key_pos + 2'd1;
            bytes_remaining = bytes_remaining - 64'd1;
            r.last_payload = (bytes_remaining == '0);
            frame_results_due.push_back(r);
            if (r.last_payload) parse_phase = eob ? AWAIT_HDR0 : DISCARD;
            else if (eob) abort_frame(ERR_SHORT_BUF, eob);
         end
         default: begin
            if (eob) parse_phase = AWAIT_HDR0;
         end
      endcase
   endtask

   // Move the scratch buffer into the send queue, flagging its last byte
   task automatic flush_buffer();
      raw_byte_type entry;
      foreach (frame_bytes[i]) begin
         entry.value = frame_bytes[i];
         entry.ends_buffer = (i == frame_bytes.size() - 1);
         unsent_bytes.push_back(entry);
      end
      phase_bytes += frame_bytes.size();
      frame_bytes.delete();
   endtask

   // The special cases, each in a buffer of its own
   task automatic queue_directed_buffers();
      // buffer ends on the first header byte
      frame_bytes = '{8'h8A};
      flush_buffer();
      // MASK bit clear in the second header byte
      frame_bytes = '{8'h81, 8'h05};
      flush_buffer();
      // buffer ends inside a 16-bit length extension
      frame_bytes = '{8'h80, 8'hFE, 8'h12};
      flush_buffer();
      // empty payload, all-ones bytes, last key byte ends the buffer
      frame_bytes = '{8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      flush_buffer();
      // nonzero length, last key byte ends the buffer
      frame_bytes = '{8'h00, 8'h83, 8'h00, 8'h11, 8'h22, 8'h33};
      flush_buffer();
      // buffer ends after the first of two payload bytes
      frame_bytes = '{8'h82, 8'h82, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00};
      flush_buffer();
   endtask

   // One random buffer: mostly a well-formed masked frame with random content,
   // otherwise noise, an unmasked frame, a truncated header or short payload
   task automatic queue_random_buffer();
      int          pick;
      int          sel;
      int          enc;
      int          sent;
      int          cut;
      int          hdr_len;
      logic        masked;
      logic [63:0] length;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      end else begin
         masked = (pick >= 14);
         sel = $urandom_range(0, 11);
         case (sel)
            0, 1, 2, 3, 4, 5: length = 64'($urandom_range(0, 20));
            6: length = '0;
            7: length = 64'($urandom_range(21, 125));
            8: length = 64'($urandom_range(126, 200));
            9: length = {32'($urandom), 32'($urandom)};
            10: length = $urandom_range(0, 1) ? 64'hFFFF : '1;
            default: begin
               // probe the limit from both sides where it is small
               if (length_limit <= 64'd200) length = length_limit + $urandom_range(0, 1);
               else length = 64'($urandom_range(0, 20));
            end
         endcase
         if (length <= 64'd125) begin
            // sometimes use a longer encoding than needed
            enc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
         end else if (length <= 64'hFFFF) begin
            enc = $urandom_range(1, 2);
         end else begin
            enc = 2;
         end
         frame_bytes.push_back(8'($urandom));
         case (enc)
            0: frame_bytes.push_back({masked, length[6:0]});
            1: begin
               frame_bytes.push_back({masked, LEN7_EXT16});
               frame_bytes.push_back(length[15:8]);
               frame_bytes.push_back(length[7:0]);
            end
            default: begin
               frame_bytes.push_back({masked, LEN7_EXT64});
               for (int i = 7; i >= 0; i--) frame_bytes.push_back(length[8 * i +: 8]);
            end
         endcase
         repeat (4) frame_bytes.push_back(8'($urandom));
         hdr_len = frame_bytes.size();
         sent = (length <= 64'd200) ? int'(length) : $urandom_range(0, 8);
         if ($urandom_range(0, 7) == 0) sent = $urandom_range(0, sent);
         repeat (sent) frame_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, hdr_len);
            while (frame_bytes.size() > cut) frame_bytes.delete(frame_bytes.size() - 1);
         end
         // trailing bytes that the decoder must drop
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
         end
      end
      flush_buffer();
   endtask

   // Wait until every byte is in and every owed result is out, then let
   // the pipeline settle
   task automatic drain();
      while (unsent_bytes.size() != 0 || req_tvalid || frame_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length_limit(input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      length_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int s_mode, input int r_mode, input bit stall_sink,
                            input bit with_directed);
      @(negedge clock);
      sender_mode = s_mode;
      receiver_mode = r_mode;
      if (stall_sink) hold_request = 1'b1;
      @(posedge clock);
      phase_bytes = 0;
      if (with_directed) queue_directed_buffers();
      while (phase_bytes < ITEMS_PER_PHASE) queue_random_buffer();
      drain();
   endtask

   // Sender: hold the offered item until taken, then idle for a drawn number
   // of cycles before offering the next one
   always @(negedge clock) begin : byte_sender
      logic       next_valid;
      logic [7:0] next_data;
      logic       next_last;
      next_valid = req_tvalid;
      next_data = req_tdata;
      next_last = req_tlast;
      if (req_accepted) begin
         req_accepted = 1'b0;
         unsent_bytes.delete(0);
         req_gap = draw_gap(sender_mode);
         next_valid = 1'b0;
      end
      if (!next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (unsent_bytes.size() != 0) begin
            next_valid = 1'b1;
            next_data = unsent_bytes[0].value;
            next_last = unsent_bytes[0].ends_buffer;
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
      req_tlast <= next_last;
   end

   // Predict on every accepted byte, at the edge that takes it
   always @(posedge clock) begin : byte_intake
      if (!reset && req_tvalid && req_tready) begin
         decode_frame_byte(req_tdata, req_tlast);
         req_accepted = 1'b1;
      end
   end

   // Long sink stall: counted here, armed by the sequencer
   always @(posedge clock) begin : sink_hold
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = SINK_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left--;
      end
   end

   // Receiver: drop ready for a drawn number of cycles after each item,
   // and for the whole of a long hold
   always @(negedge clock) begin : result_sink
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_gap = draw_gap(receiver_mode);
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each taken result with the oldest one owed
   always @(posedge clock) begin : result_monitor
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("result with none owed, kind %0d", rsp_tuser));
         end else begin
            want = frame_results_due.pop_front();
            check_field("kind", 64'(rsp_tuser), 64'(want.kind));
            check_field("data_byte", 64'(rsp_tdata[7:0]), 64'(want.data_byte));
            check_field("final_flag", 64'(rsp_tdata[8]), 64'(want.final_flag));
            check_field("frame_opcode", 64'(rsp_tdata[12:9]), 64'(want.frame_opcode));
            check_field("payload_length", rsp_tdata[76:13], want.payload_length);
            check_field("error_code", 64'(rsp_tdata[78:77]), 64'(want.error_code));
            check_field("pad bit", 64'(rsp_tdata[79]), '0);
            check_field("last_payload", 64'(rsp_tlast), 64'(want.last_payload));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("websocket_frame_deframer_test: errors");
         $finish;
      end
   end

   initial begin : sequencer
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limit first, with the special cases up front
      run_phase(IDLE_ALWAYS, IDLE_ALWAYS, 1'b0, 1'b1);
      write_length_limit('1);
      run_phase(IDLE_NONE, IDLE_NONE, 1'b0, 1'b0);
      write_length_limit('0);
      run_phase(IDLE_SPARSE, IDLE_ALWAYS, 1'b0, 1'b0);
      // stall the sink long while bytes keep coming, so the block backs up
      write_length_limit(64'($urandom_range(0, 40)));
      run_phase(IDLE_NONE, IDLE_ALWAYS, 1'b1, 1'b0);
      write_length_limit(64'd125);
      run_phase(IDLE_ALWAYS, IDLE_SPARSE, 1'b0, 1'b0);
      write_length_limit(64'd126);
      run_phase(IDLE_ALWAYS, IDLE_NONE, 1'b0, 1'b0);
      write_length_limit(64'h8000_0000_0000_0000);
      run_phase(IDLE_SPARSE, IDLE_SPARSE, 1'b0, 1'b0);
      write_length_limit(64'($urandom_range(0, 200)));
      run_phase(IDLE_ALWAYS, IDLE_ALWAYS, 1'b0, 1'b0);

      if (mismatch_count == 0) begin
         $display("websocket_frame_deframer_test: clean");
      end else begin
         $display("websocket_frame_deframer_test: errors");
      end
      $finish;
   end

endmodule
